/* src/famps_pkg.sv */
`default_nettype none

package famps_pkg;

    localparam int KEY_BITS    = 20;
    localparam int NUMBER_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ARRIVE        = 2'd0,
        CMD_SERVE_OLDEST  = 2'd1,
        CMD_SERVE_HIGHEST = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [KEY_BITS-1:0] key;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [NUMBER_BITS-1:0] entry_number;
    } t_out_item;

    // write strobes from the sequencer into the entry store
    typedef struct packed {
        logic arrive_we;
        logic mark_we;
    } t_store_ctl;

endpackage

`default_nettype wire

/* src/fifo_and_max_priority_server.sv */
// arrive, empty serve or unknown command: the accepted item goes straight to the result state
// serve oldest: first read, take, then while entries remain a drop read and check per front slot up to an unserved one
// serve highest: first read, a scan over the live span, take, plus the same front skipping when the front entry wins
// one item at a time; the scan reads one ring slot a cycle through the store read port
// next item is taken while the previous result still waits in the output register
// reset (synchronous, active low) empties the pool and sets the next arrival number to 1
`default_nettype none

module fifo_and_max_priority_server #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  famps_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output famps_pkg::t_out_item o_out_item
);
    import famps_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int SW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SCAN,
        S_TAKE,
        S_DROP_RD,
        S_DROP_CK,
        S_RESULT
    } t_state;

    // ring bookkeeping
    t_state                 r_state;
    logic [IW-1:0]          r_oldest;
    logic [SW-1:0]          r_span;
    logic [NUMBER_BITS-1:0] r_next;

    // item being worked on
    t_cmd                   r_cmd;
    logic [IW-1:0]          r_best;
    logic [KEY_BITS-1:0]    r_best_key;
    logic [NUMBER_BITS-1:0] r_best_num;
    logic [IW-1:0]          r_scan_slot;
    logic [SW-1:0]          r_idx;
    t_out_item              r_res;

    // output register
    logic                   r_out_valid;
    t_out_item              r_out_item;

    // store interface
    t_store_ctl             w_ctl;
    logic [IW-1:0]          w_waddr;
    logic [IW-1:0]          w_raddr;
    logic [KEY_BITS-1:0]    w_rd_key;
    logic [NUMBER_BITS-1:0] w_rd_num;
    logic                   w_rd_served;

    logic [IW:0]            w_tail_sum;
    logic [IW-1:0]          w_tail;
    logic [IW-1:0]          w_oldest_inc;
    logic [IW-1:0]          w_scan_inc;
    logic                   w_in_fire;
    logic                   w_full;
    logic                   w_out_free;

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] slot);
        logic [IW-1:0] nxt;
        if (slot == IW'(POOL_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = slot + 1'b1;
        end
        return nxt;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_full     = (r_span == SW'(POOL_DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;

    // free slot after the newest entry; span is below depth whenever this is used
    assign w_tail_sum = {1'b0, r_oldest} + (IW+1)'(r_span);
    always_comb begin
        if (w_tail_sum >= (IW+1)'(POOL_DEPTH)) begin
            w_tail = IW'(w_tail_sum - (IW+1)'(POOL_DEPTH));
        end else begin
            w_tail = IW'(w_tail_sum);
        end
    end

    assign w_oldest_inc = ring_inc(r_oldest);
    assign w_scan_inc   = ring_inc(r_scan_slot);

    assign w_ctl.arrive_we = w_in_fire && (i_in_item.cmd == CMD_ARRIVE) && !w_full;
    assign w_ctl.mark_we   = (r_state == S_TAKE);
    assign w_waddr         = (r_state == S_TAKE) ? r_best : w_tail;

    // read address: scan walks the ring, otherwise the front slot is watched
    always_comb begin
        unique case (r_state)
            S_FIRST: w_raddr = w_oldest_inc;
            S_SCAN:  w_raddr = w_scan_inc;
            default: w_raddr = r_oldest;
        endcase
    end

    famps_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_waddr     (w_waddr),
        .i_wr_key    (i_in_item.key),
        .i_wr_num    (r_next),
        .i_raddr     (w_raddr),
        .o_rd_key    (w_rd_key),
        .o_rd_num    (w_rd_num),
        .o_rd_served (w_rd_served)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_span      <= '0;
            r_next      <= NUMBER_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            // the result state loads the output register itself
            if (i_out_ready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_cmd  <= i_in_item.cmd;
                        r_best <= r_oldest;
                        unique case (i_in_item.cmd)
                            CMD_ARRIVE: begin
                                r_state <= S_RESULT;
                                if (w_full) begin
                                    r_res <= '{status: ST_FULL, entry_number: '0};
                                end else begin
                                    r_res  <= '{status: ST_ACCEPTED, entry_number: r_next};
                                    r_span <= r_span + 1'b1;
                                    // numbers wrap from all ones back to one
                                    if (r_next == {NUMBER_BITS{1'b1}}) begin
                                        r_next <= NUMBER_BITS'(1);
                                    end else begin
                                        r_next <= r_next + 1'b1;
                                    end
                                end
                            end
                            CMD_SERVE_OLDEST, CMD_SERVE_HIGHEST: begin
                                r_res   <= '{status: ST_EMPTY, entry_number: '0};
                                r_state <= (r_span != '0) ? S_FIRST : S_RESULT;
                            end
                            default: begin
                                // unknown command reports empty
                                r_res   <= '{status: ST_EMPTY, entry_number: '0};
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_FIRST: begin
                    // front entry is always unserved: start the best from it
                    r_best_key <= w_rd_key;
                    r_best_num <= w_rd_num;
                    if (r_cmd == CMD_SERVE_HIGHEST && r_span > SW'(1)) begin
                        r_scan_slot <= w_oldest_inc;
                        r_idx       <= SW'(2);
                        r_state     <= S_SCAN;
                    end else begin
                        r_state <= S_TAKE;
                    end
                end

                S_SCAN: begin
                    // strict greater keeps the earliest arrival on a tie
                    if (!w_rd_served && (w_rd_key > r_best_key)) begin
                        r_best     <= r_scan_slot;
                        r_best_key <= w_rd_key;
                        r_best_num <= w_rd_num;
                    end
                    if (r_idx < r_span) begin
                        r_scan_slot <= w_scan_inc;
                        r_idx       <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_TAKE;
                    end
                end

                S_TAKE: begin
                    r_res <= '{status: ST_SERVED, entry_number: r_best_num};
                    if (r_best == r_oldest) begin
                        r_oldest <= w_oldest_inc;
                        r_span   <= r_span - 1'b1;
                        r_state  <= (r_span > SW'(1)) ? S_DROP_RD : S_RESULT;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end

                S_DROP_RD: begin
                    // mark of the new front slot arrives next cycle
                    r_state <= S_DROP_CK;
                end

                S_DROP_CK: begin
                    if (w_rd_served) begin
                        r_oldest <= w_oldest_inc;
                        r_span   <= r_span - 1'b1;
                        r_state  <= (r_span > SW'(1)) ? S_DROP_RD : S_RESULT;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end

                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/famps_store.sv */
`default_nettype none

module famps_store #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  famps_pkg::t_store_ctl             i_ctl,
    input  logic [$clog2(POOL_DEPTH)-1:0]     i_waddr,
    input  logic [famps_pkg::KEY_BITS-1:0]    i_wr_key,
    input  logic [famps_pkg::NUMBER_BITS-1:0] i_wr_num,
    input  logic [$clog2(POOL_DEPTH)-1:0]     i_raddr,
    output logic [famps_pkg::KEY_BITS-1:0]    o_rd_key,
    output logic [famps_pkg::NUMBER_BITS-1:0] o_rd_num,
    output logic                              o_rd_served
);
    import famps_pkg::*;

    logic [KEY_BITS-1:0]    r_key_mem    [POOL_DEPTH];
    logic [NUMBER_BITS-1:0] r_num_mem    [POOL_DEPTH];
    logic                   r_served_mem [POOL_DEPTH];

    // key and number are written only on arrival
    always_ff @(posedge i_clk) begin
        if (i_ctl.arrive_we) begin
            r_key_mem[i_waddr] <= i_wr_key;
            r_num_mem[i_waddr] <= i_wr_num;
        end
        o_rd_key <= r_key_mem[i_raddr];
        o_rd_num <= r_num_mem[i_raddr];
    end

    // served mark: cleared on arrival, set on serve
    always_ff @(posedge i_clk) begin
        if (i_ctl.arrive_we || i_ctl.mark_we) begin
            r_served_mem[i_waddr] <= i_ctl.mark_we;
        end
        o_rd_served <= r_served_mem[i_raddr];
    end

endmodule

`default_nettype wire
